FILE: design/sip_pkg.sv
// Shared types, widths and codes for the segment intersection parameter unit.
package sip_pkg;

    // Coordinate and parameter widths fixed by the payload words.
    localparam int CW     = 16;
    localparam int FW     = 16;
    localparam int EPS_W  = 16;
    localparam int PW     = FW + 1;

    // Derived datapath widths.
    localparam int DIFF_W = CW + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int CR_W   = PROD_W + 1;
    localparam int LEN_W  = PROD_W;
    localparam int SQ_K   = (CR_W + 1) / 2;
    localparam int SQ_H   = CR_W - SQ_K;
    localparam int SQ_W   = 2 * CR_W;
    localparam int EPS2_W = 2 * EPS_W;
    localparam int LIM_K  = (LEN_W + 1) / 2;
    localparam int LIM_H  = LEN_W - LIM_K;
    localparam int LIM_W  = EPS2_W + LEN_W;
    localparam int CMP_W  = (SQ_W > LIM_W) ? SQ_W : LIM_W;
    localparam int DEN_W  = CR_W + 1;
    localparam int DM_W   = DEN_W;
    localparam int RM_W   = DM_W + 1;
    localparam logic [PW-1:0] PARAM_ONE = PW'(1) << FW;

    // Result codes.
    typedef enum logic [1:0] {
        OUT_INTERSECT  = 2'd0,
        OUT_APART      = 2'd1,
        OUT_COINCIDENT = 2'd2
    } outcome_t;

    typedef struct packed {
        logic signed [CW-1:0] a_start_x;
        logic signed [CW-1:0] a_start_y;
        logic signed [CW-1:0] a_end_x;
        logic signed [CW-1:0] a_end_y;
        logic signed [CW-1:0] b_start_x;
        logic signed [CW-1:0] b_start_y;
        logic signed [CW-1:0] b_end_x;
        logic signed [CW-1:0] b_end_y;
    } in_word_t;

    typedef struct packed {
        outcome_t        outcome;
        logic [PW-1:0]   param_on_a;
    } out_word_t;

    // Cross products and squared lengths leaving the front end.
    typedef struct packed {
        logic signed [CR_W-1:0] c21;
        logic signed [CR_W-1:0] c22;
        logic signed [CR_W-1:0] c11;
        logic signed [CR_W-1:0] c12;
        logic [LEN_W-1:0]       la;
        logic [LEN_W-1:0]       lb;
        logic                   zero_len;
    } cross_t;

    // Word carried through the divider stages.
    typedef struct packed {
        outcome_t          outcome;
        logic              pzero;
        logic              psat;
        logic [DM_W-1:0]   rem;
        logic [DM_W-1:0]   dmag;
        logic [FW-1:0]     quo;
    } div_t;

    // Difference of two coordinates, one bit wider.
    function automatic logic signed [DIFF_W-1:0] dif(logic signed [CW-1:0] a,
                                                     logic signed [CW-1:0] b);
        logic signed [DIFF_W-1:0] ea;
        logic signed [DIFF_W-1:0] eb;
        ea = DIFF_W'(a);
        eb = DIFF_W'(b);
        return ea - eb;
    endfunction

endpackage

FILE: design/segment_intersection_param_unit.sv
// Top level of the segment intersection parameter unit.
// Throughput: one word per cycle; busy stays low, as every stage advances each cycle.
// Front end and tests take seven stages, the quotient one stage per fraction bit, plus output.
// Reset clears all valid bits and sets epsilon to 1; no result is pending after reset.
// The receiver cannot stall, so results leave on the strobe without back pressure.
module segment_intersection_param_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  sip_pkg::in_word_t  seg_in,
    output sip_pkg::out_word_t result,
    output logic               result_valid,
    input  logic               cfg_we,
    input  logic [sip_pkg::EPS_W-1:0] cfg_data
);

    localparam int FW  = sip_pkg::FW;
    localparam int LAT = 8 + FW;

    logic [sip_pkg::EPS_W-1:0]  epsilon_reg;
    logic [sip_pkg::EPS2_W-1:0] eps2_reg;
    logic                       fv;
    sip_pkg::cross_t            fw;
    logic                       dv [FW+1];
    sip_pkg::div_t              dw [FW+1];
    sip_pkg::out_word_t         res_reg;
    sip_pkg::out_word_t         res_next;
    logic                       rv_reg;

    assign busy = 1'b0;

    // Tolerance register and its square.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epsilon_reg <= sip_pkg::EPS_W'(1);
            eps2_reg    <= sip_pkg::EPS2_W'(1);
        end
        else
        begin
            if (cfg_we)
            begin
                epsilon_reg <= cfg_data;
            end
            eps2_reg <= sip_pkg::EPS2_W'(epsilon_reg) * sip_pkg::EPS2_W'(epsilon_reg);
        end
    end

    sip_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .seg      (seg_in),
        .out_valid(fv),
        .out_word (fw)
    );

    sip_test u_test
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (fv),
        .cr       (fw),
        .eps2     (eps2_reg),
        .out_valid(dv[0]),
        .out_word (dw[0])
    );

    // Divider chain, one stage per fraction bit.
    for (genvar g = 0; g < FW; g++)
    begin : g_div
        sip_div_stage u_stage
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_valid (dv[g]),
            .in_word  (dw[g]),
            .out_valid(dv[g+1]),
            .out_word (dw[g+1])
        );
    end

    // Final parameter selection with saturation.
    always_comb
    begin
        res_next.outcome = dw[FW].outcome;
        if (dw[FW].outcome != sip_pkg::OUT_INTERSECT || dw[FW].pzero)
        begin
            res_next.param_on_a = '0;
        end
        else if (dw[FW].psat)
        begin
            res_next.param_on_a = sip_pkg::PARAM_ONE;
        end
        else
        begin
            res_next.param_on_a = sip_pkg::PW'(dw[FW].quo);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= 1'b0;
        end
        else
        begin
            rv_reg <= dv[FW];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result       = res_reg;
    assign result_valid = rv_reg;

    // Every accepted word gives a result after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT result_valid)
        else $error("result word missing after latency");

    // A nonzero parameter only comes with an intersection.
    a_param_only_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.param_on_a != '0) |->
        (result.outcome == sip_pkg::OUT_INTERSECT))
        else $error("parameter set without intersection");

    // The parameter never exceeds one.
    a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.param_on_a <= sip_pkg::PARAM_ONE))
        else $error("parameter above one");

endmodule

FILE: design/sip_front.sv
// Front end: coordinate differences, products, cross products and squared lengths.
module sip_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  sip_pkg::in_word_t seg,
    output logic              out_valid,
    output sip_pkg::cross_t   out_word
);

    localparam int DW = sip_pkg::DIFF_W;
    localparam int PWD = sip_pkg::PROD_W;
    localparam int CRW = sip_pkg::CR_W;
    localparam int LW = sip_pkg::LEN_W;

    // Stage 1 registers: differences.
    logic signed [DW-1:0] adx_reg, ady_reg, bdx_reg, bdy_reg;
    logic signed [DW-1:0] o21x_reg, o21y_reg, o22x_reg, o22y_reg;
    logic signed [DW-1:0] o11x_reg, o11y_reg, o12x_reg, o12y_reg;
    logic                 zl1_reg, v1_reg;

    // Stage 2 registers: products.
    logic signed [PWD-1:0] p21a_reg, p21b_reg, p22a_reg, p22b_reg;
    logic signed [PWD-1:0] p11a_reg, p11b_reg, p12a_reg, p12b_reg;
    logic signed [PWD-1:0] sax_reg, say_reg, sbx_reg, sby_reg;
    logic                  zl2_reg, v2_reg;

    // Stage 3 registers: cross products and lengths.
    sip_pkg::cross_t cr_reg;
    logic            v3_reg;

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage 1: segment directions and endpoint offsets.
    always_ff @(posedge clk)
    begin
        adx_reg  <= sip_pkg::dif(seg.a_end_x, seg.a_start_x);
        ady_reg  <= sip_pkg::dif(seg.a_end_y, seg.a_start_y);
        bdx_reg  <= sip_pkg::dif(seg.b_end_x, seg.b_start_x);
        bdy_reg  <= sip_pkg::dif(seg.b_end_y, seg.b_start_y);
        o21x_reg <= sip_pkg::dif(seg.b_start_x, seg.a_start_x);
        o21y_reg <= sip_pkg::dif(seg.b_start_y, seg.a_start_y);
        o22x_reg <= sip_pkg::dif(seg.b_end_x, seg.a_start_x);
        o22y_reg <= sip_pkg::dif(seg.b_end_y, seg.a_start_y);
        o11x_reg <= sip_pkg::dif(seg.a_start_x, seg.b_start_x);
        o11y_reg <= sip_pkg::dif(seg.a_start_y, seg.b_start_y);
        o12x_reg <= sip_pkg::dif(seg.a_end_x, seg.b_start_x);
        o12y_reg <= sip_pkg::dif(seg.a_end_y, seg.b_start_y);
        zl1_reg  <= ((seg.a_start_x == seg.a_end_x) && (seg.a_start_y == seg.a_end_y)) ||
                    ((seg.b_start_x == seg.b_end_x) && (seg.b_start_y == seg.b_end_y));
    end

    // Stage 2: one multiplier per product term.
    always_ff @(posedge clk)
    begin
        p21a_reg <= PWD'(adx_reg) * PWD'(o21y_reg);
        p21b_reg <= PWD'(ady_reg) * PWD'(o21x_reg);
        p22a_reg <= PWD'(adx_reg) * PWD'(o22y_reg);
        p22b_reg <= PWD'(ady_reg) * PWD'(o22x_reg);
        p11a_reg <= PWD'(bdx_reg) * PWD'(o11y_reg);
        p11b_reg <= PWD'(bdy_reg) * PWD'(o11x_reg);
        p12a_reg <= PWD'(bdx_reg) * PWD'(o12y_reg);
        p12b_reg <= PWD'(bdy_reg) * PWD'(o12x_reg);
        sax_reg  <= PWD'(adx_reg) * PWD'(adx_reg);
        say_reg  <= PWD'(ady_reg) * PWD'(ady_reg);
        sbx_reg  <= PWD'(bdx_reg) * PWD'(bdx_reg);
        sby_reg  <= PWD'(bdy_reg) * PWD'(bdy_reg);
        zl2_reg  <= zl1_reg;
    end

    // Stage 3: cross products as differences, squared lengths as sums.
    always_ff @(posedge clk)
    begin
        cr_reg.c21      <= CRW'(p21a_reg) - CRW'(p21b_reg);
        cr_reg.c22      <= CRW'(p22a_reg) - CRW'(p22b_reg);
        cr_reg.c11      <= CRW'(p11a_reg) - CRW'(p11b_reg);
        cr_reg.c12      <= CRW'(p12a_reg) - CRW'(p12b_reg);
        cr_reg.la       <= LW'(unsigned'(sax_reg)) + LW'(unsigned'(say_reg));
        cr_reg.lb       <= LW'(unsigned'(sbx_reg)) + LW'(unsigned'(sby_reg));
        cr_reg.zero_len <= zl2_reg;
    end

    assign out_valid = v3_reg;
    assign out_word  = cr_reg;

endmodule

FILE: design/sip_test.sv
// Distance tests against the tolerance and the outcome decision.
module sip_test
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  sip_pkg::cross_t            cr,
    input  logic [sip_pkg::EPS2_W-1:0] eps2,
    output logic                       out_valid,
    output sip_pkg::div_t              out_word
);

    localparam int CRW = sip_pkg::CR_W;
    localparam int K   = sip_pkg::SQ_K;
    localparam int H   = sip_pkg::SQ_H;
    localparam int SW  = sip_pkg::SQ_W;
    localparam int LK  = sip_pkg::LIM_K;
    localparam int LH  = sip_pkg::LIM_H;
    localparam int E2W = sip_pkg::EPS2_W;
    localparam int LMW = sip_pkg::LIM_W;
    localparam int CMW = sip_pkg::CMP_W;
    localparam int DNW = sip_pkg::DEN_W;
    localparam int DMW = sip_pkg::DM_W;

    // Stage 4 registers: partial products of the squares and limits.
    logic [2*H-1:0]    hh_reg [4];
    logic [H+K-1:0]    hl_reg [4];
    logic [2*K-1:0]    ll_reg [4];
    logic [E2W+LH-1:0] lah_reg, lbh_reg;
    logic [E2W+LK-1:0] lal_reg, lbl_reg;
    logic [3:0]        neg4_reg, zero4_reg;
    logic signed [CRW-1:0] c11_4_reg, c12_4_reg;
    logic              zl4_reg, v4_reg;

    // Stage 5 registers: full squares, limits and denominator.
    logic [SW-1:0]     sq_reg [4];
    logic [LMW-1:0]    lima_reg, limb_reg;
    logic signed [DNW-1:0] den_reg;
    logic signed [CRW-1:0] c11_5_reg;
    logic [3:0]        neg5_reg, zero5_reg;
    logic              zl5_reg, v5_reg;

    // Stage 6 registers: comparison flags and magnitudes.
    logic              sa_apart_reg, sa_near_reg, sb_apart_reg, den_zero_reg;
    logic              pzero6_reg, zl6_reg, v6_reg;
    logic [DMW-1:0]    num_reg, dmag_reg;

    // Stage 7 register: decided outcome.
    sip_pkg::div_t     d7_reg;
    logic              v7_reg;

    logic signed [CRW-1:0] cv [4];
    logic [CRW-1:0]        mag [4];
    logic [3:0]            gt, lt;
    sip_pkg::outcome_t     oc_next;
    logic [CMW-1:0]        sqe [4];
    logic [CMW-1:0]        lae, lbe;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= in_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // Magnitudes of the four cross products.
    always_comb
    begin
        cv[0] = cr.c21;
        cv[1] = cr.c22;
        cv[2] = cr.c11;
        cv[3] = cr.c12;
        for (int i = 0; i < 4; i++)
        begin
            mag[i] = cv[i][CRW-1] ? CRW'(-cv[i]) : CRW'(cv[i]);
        end
    end

    // Stage 4: split each square and each limit into narrow products.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            hh_reg[i]   <= (2*H)'(mag[i][CRW-1:K]) * (2*H)'(mag[i][CRW-1:K]);
            hl_reg[i]   <= (H+K)'(mag[i][CRW-1:K]) * (H+K)'(mag[i][K-1:0]);
            ll_reg[i]   <= (2*K)'(mag[i][K-1:0]) * (2*K)'(mag[i][K-1:0]);
            neg4_reg[i] <= cv[i][CRW-1];
            zero4_reg[i] <= (cv[i] == '0);
        end
        lah_reg   <= (E2W+LH)'(eps2) * (E2W+LH)'(cr.la[LK+LH-1:LK]);
        lal_reg   <= (E2W+LK)'(eps2) * (E2W+LK)'(cr.la[LK-1:0]);
        lbh_reg   <= (E2W+LH)'(eps2) * (E2W+LH)'(cr.lb[LK+LH-1:LK]);
        lbl_reg   <= (E2W+LK)'(eps2) * (E2W+LK)'(cr.lb[LK-1:0]);
        c11_4_reg <= cr.c11;
        c12_4_reg <= cr.c12;
        zl4_reg   <= cr.zero_len;
    end

    // Stage 5: recombine the partial products.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            sq_reg[i] <= (SW'(hh_reg[i]) << (2*K)) + (SW'(hl_reg[i]) << (K+1)) +
                         SW'(ll_reg[i]);
        end
        lima_reg  <= (LMW'(lah_reg) << LK) + LMW'(lal_reg);
        limb_reg  <= (LMW'(lbh_reg) << LK) + LMW'(lbl_reg);
        den_reg   <= DNW'(c11_4_reg) - DNW'(c12_4_reg);
        c11_5_reg <= c11_4_reg;
        neg5_reg  <= neg4_reg;
        zero5_reg <= zero4_reg;
        zl5_reg   <= zl4_reg;
    end

    // Squared distances against the squared tolerance of their line.
    always_comb
    begin
        lae = CMW'(lima_reg);
        lbe = CMW'(limb_reg);
        for (int i = 0; i < 4; i++)
        begin
            sqe[i] = CMW'(sq_reg[i]);
            gt[i]  = (i < 2) ? (sqe[i] > lae) : (sqe[i] > lbe);
            lt[i]  = (i < 2) ? (sqe[i] < lae) : (sqe[i] < lbe);
        end
    end

    // Stage 6: side tests and magnitudes for the divider.
    always_ff @(posedge clk)
    begin
        sa_apart_reg <= (((!neg5_reg[0] && !zero5_reg[0]) && (!neg5_reg[1] && !zero5_reg[1])) ||
                         (neg5_reg[0] && neg5_reg[1])) && gt[0] && gt[1];
        sa_near_reg  <= lt[0] && lt[1];
        sb_apart_reg <= (((!neg5_reg[2] && !zero5_reg[2]) && (!neg5_reg[3] && !zero5_reg[3])) ||
                         (neg5_reg[2] && neg5_reg[3])) && gt[2] && gt[3];
        den_zero_reg <= (den_reg == '0);
        pzero6_reg   <= zero5_reg[2] || (neg5_reg[2] != den_reg[DNW-1]);
        num_reg      <= c11_5_reg[CRW-1] ? DMW'(-DNW'(c11_5_reg)) : DMW'(c11_5_reg);
        dmag_reg     <= den_reg[DNW-1] ? DMW'(-den_reg) : DMW'(den_reg);
        zl6_reg      <= zl5_reg;
    end

    // Rules applied in order of priority.
    always_comb
    begin
        if (zl6_reg || sa_apart_reg)
        begin
            oc_next = sip_pkg::OUT_APART;
        end
        else if (sa_near_reg)
        begin
            oc_next = sip_pkg::OUT_COINCIDENT;
        end
        else if (sb_apart_reg)
        begin
            oc_next = sip_pkg::OUT_APART;
        end
        else if (den_zero_reg)
        begin
            oc_next = sip_pkg::OUT_COINCIDENT;
        end
        else
        begin
            oc_next = sip_pkg::OUT_INTERSECT;
        end
    end

    // Stage 7: outcome and divider seed.
    always_ff @(posedge clk)
    begin
        d7_reg.outcome <= oc_next;
        d7_reg.pzero   <= pzero6_reg;
        d7_reg.psat    <= (num_reg >= dmag_reg);
        d7_reg.rem     <= num_reg;
        d7_reg.dmag    <= dmag_reg;
        d7_reg.quo     <= '0;
    end

    assign out_valid = v7_reg;
    assign out_word  = d7_reg;

endmodule

FILE: design/sip_div_stage.sv
// One restoring division step: one quotient bit per stage.
module sip_div_stage
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  sip_pkg::div_t in_word,
    output logic          out_valid,
    output sip_pkg::div_t out_word
);

    localparam int DMW = sip_pkg::DM_W;
    localparam int RMW = sip_pkg::RM_W;

    sip_pkg::div_t  d_reg;
    sip_pkg::div_t  d_next;
    logic           v_reg;
    logic [RMW-1:0] r2;
    logic [RMW-1:0] dm;

    // Shift the remainder and subtract the divisor where it fits.
    always_comb
    begin
        d_next = in_word;
        r2     = {in_word.rem, 1'b0};
        dm     = RMW'(in_word.dmag);
        if (r2 >= dm)
        begin
            d_next.rem = DMW'(r2 - dm);
            d_next.quo = {in_word.quo[sip_pkg::FW-2:0], 1'b1};
        end
        else
        begin
            d_next.rem = DMW'(r2);
            d_next.quo = {in_word.quo[sip_pkg::FW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    assign out_valid = v_reg;
    assign out_word  = d_reg;

endmodule

FILE: verif/tb_top.sv
// Testbench for the segment intersection parameter unit: scoreboard class and stimulus.
`timescale 1ns / 1ps

module tb_top;

    localparam int LATENCY     = 8 + sip_pkg::FW;
    localparam int CYCLE_LIMIT = 400000;

    // Scoreboard: predicts each result word from the accepted input word.
    class crossing_scoreboard;
        sip_pkg::out_word_t pending[$];
        logic [15:0] eps;
        int          errors;
        int          checked;
        int          hits[3];

        function void reset_eps();
            eps = 16'd1;
        endfunction

        // Classify two cross products against the tolerance limit:
        // 1 both far on one side, 2 both near, 0 otherwise.
        function int classify(logic signed [127:0] p1, logic signed [127:0] p2,
                              logic signed [127:0] lim);
            logic signed [127:0] s1;
            logic signed [127:0] s2;
            s1 = p1 * p1;
            s2 = p2 * p2;
            if (((p1 > 0 && p2 > 0) || (p1 < 0 && p2 < 0)) && s1 > lim && s2 > lim)
                return 1;
            if (s1 < lim && s2 < lim)
                return 2;
            return 0;
        endfunction

        function sip_pkg::out_word_t predict(sip_pkg::in_word_t w);
            logic signed [127:0] ax1, ay1, bx1, by1, adx, ady, bdx, bdy;
            logic signed [127:0] e2, la, lb, c21, c22, c11, c12, den, num, dm, rem;
            logic [sip_pkg::FW-1:0] q;
            int s;
            sip_pkg::out_word_t r;
            r.outcome = sip_pkg::OUT_APART;
            r.param_on_a = '0;
            ax1 = w.a_start_x; ay1 = w.a_start_y;
            bx1 = w.b_start_x; by1 = w.b_start_y;
            adx = 128'(signed'(w.a_end_x)) - ax1;
            ady = 128'(signed'(w.a_end_y)) - ay1;
            bdx = 128'(signed'(w.b_end_x)) - bx1;
            bdy = 128'(signed'(w.b_end_y)) - by1;
            if ((adx == 0 && ady == 0) || (bdx == 0 && bdy == 0))
                return r;
            e2 = $signed({112'd0, eps}) * $signed({112'd0, eps});
            la = adx * adx + ady * ady;
            lb = bdx * bdx + bdy * bdy;
            c21 = adx * (by1 - ay1) - ady * (bx1 - ax1);
            c22 = adx * (128'(signed'(w.b_end_y)) - ay1) - ady * (128'(signed'(w.b_end_x)) - ax1);
            s = classify(c21, c22, e2 * la);
            if (s == 2)
            begin
                r.outcome = sip_pkg::OUT_COINCIDENT;
                return r;
            end
            if (s == 1)
                return r;
            c11 = bdx * (ay1 - by1) - bdy * (ax1 - bx1);
            c12 = bdx * (128'(signed'(w.a_end_y)) - by1) - bdy * (128'(signed'(w.a_end_x)) - bx1);
            if (classify(c11, c12, e2 * lb) == 1)
                return r;
            den = c11 - c12;
            if (den == 0)
            begin
                r.outcome = sip_pkg::OUT_COINCIDENT;
                return r;
            end
            r.outcome = sip_pkg::OUT_INTERSECT;
            if (c11 == 0 || (c11 < 0) != (den < 0))
                return r;
            num = (c11 < 0) ? -c11 : c11;
            dm  = (den < 0) ? -den : den;
            if (num >= dm)
            begin
                r.param_on_a = sip_pkg::PARAM_ONE;
                return r;
            end
            rem = num;
            q = '0;
            for (int i = 0; i < sip_pkg::FW; i++)
            begin
                rem = rem + rem;
                q = {q[sip_pkg::FW-2:0], 1'b0};
                if (rem >= dm)
                begin
                    rem = rem - dm;
                    q[0] = 1'b1;
                end
            end
            r.param_on_a = {1'b0, q};
            return r;
        endfunction

        function void note_input(sip_pkg::in_word_t w);
            pending.push_back(predict(w));
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 40)
                $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task check_result(sip_pkg::out_word_t got);
            sip_pkg::out_word_t exp_w;
            if (pending.size() == 0)
            begin
                report_mismatch("result word with nothing expected");
                return;
            end
            exp_w = pending.pop_front();
            checked++;
            hits[exp_w.outcome]++;
            if (got.outcome !== exp_w.outcome)
                report_mismatch($sformatf("outcome %0d, expected %0d",
                                          got.outcome, exp_w.outcome));
            if (got.param_on_a !== exp_w.param_on_a)
                report_mismatch($sformatf("param_on_a %h, expected %h",
                                          got.param_on_a, exp_w.param_on_a));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    sip_pkg::in_word_t  seg_in;
    sip_pkg::out_word_t result;
    logic               result_valid;
    logic               cfg_we;
    logic [15:0]        cfg_data;

    crossing_scoreboard sb;
    int cycles;
    int sent;

    segment_intersection_param_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .seg_in       (seg_in),
        .result       (result),
        .result_valid (result_valid),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Record accepted words and check results at each rising edge.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && start && !busy)
            sb.note_input(seg_in);
        if (rst_n && result_valid)
            sb.check_result(result);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top failed");
            $finish;
        end
    end

    function automatic logic [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 64) - 32);
            default: return 16'($urandom_range(0, 2048) - 1024);
        endcase
    endfunction

    // Random segment pair, often constructed to cross, touch or lie collinear.
    function automatic sip_pkg::in_word_t rand_pair();
        sip_pkg::in_word_t w;
        int mode;
        int kind;
        int k;
        mode = $urandom_range(0, 2);
        w = {rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
             rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode)};
        kind = $urandom_range(0, 9);
        if (kind < 2)
        begin
            // B lies along A's line, a shifted copy of A.
            k = $urandom_range(0, 4) - 2;
            w.a_end_x = w.a_start_x + 16'($urandom_range(0, 200) - 100);
            w.a_end_y = w.a_start_y + 16'($urandom_range(0, 200) - 100);
            w.b_start_x = w.a_start_x + 16'(k) * (w.a_end_x - w.a_start_x);
            w.b_start_y = w.a_start_y + 16'(k) * (w.a_end_y - w.a_start_y);
            w.b_end_x = w.b_start_x + (w.a_end_x - w.a_start_x);
            w.b_end_y = w.b_start_y + (w.a_end_y - w.a_start_y);
        end
        else if (kind == 2)
        begin
            w.b_start_x = w.a_start_x;
            w.b_start_y = w.a_start_y;
        end
        else if (kind == 3)
        begin
            w.a_end_x = w.a_start_x;
            w.a_end_y = w.a_start_y;
        end
        else if (kind < 7)
        begin
            // B straddles A's midpoint.
            w.b_start_x = (w.a_start_x >>> 1) + (w.a_end_x >>> 1) + 16'($urandom_range(0, 60) - 30);
            w.b_start_y = (w.a_start_y >>> 1) + (w.a_end_y >>> 1) + 16'($urandom_range(0, 60) - 30);
            w.b_end_x = w.b_start_x - (w.b_end_x - w.b_start_x);
            w.b_end_y = w.b_start_y - (w.b_end_y - w.b_start_y);
            w.b_start_x = w.b_start_x + (w.b_start_x - w.b_end_x);
        end
        return w;
    endfunction

    // Send one word, then an optional idle gap.
    task automatic send_word(sip_pkg::in_word_t w);
        int gap;
        seg_in <= w;
        start  <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
        gap = ($urandom_range(0, 9) < 6) ? 0 :
              ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(5, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_eps(logic [15:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.eps = value;
    endtask

    task automatic directed_words();
        sip_pkg::in_word_t w;
        // Simple crossing, endpoint touch, parallel, collinear, zero length.
        send_word({16'sd0, 16'sd0, 16'sd160, 16'sd160, 16'sd0, 16'sd160, 16'sd160, 16'sd0});
        send_word({16'sd0, 16'sd0, 16'sd160, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd160});
        send_word({16'sd0, 16'sd0, 16'sd160, 16'sd0, 16'sd160, 16'sd0, 16'sd160, 16'sd50});
        send_word({16'sd0, 16'sd0, 16'sd160, 16'sd0, 16'sd0, 16'sd16, 16'sd160, 16'sd16});
        send_word({16'sd0, 16'sd0, 16'sd160, 16'sd0, 16'sd320, 16'sd0, 16'sd480, 16'sd0});
        send_word({16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd0, 16'sd0, 16'sd10, 16'sd10});
        send_word({16'sd0, 16'sd0, 16'sd10, 16'sd10, 16'sd3, 16'sd3, 16'sd3, 16'sd3});
        send_word({16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd50, 16'sd1, 16'sd50, -16'sd1});
        send_word({16'sd0, 16'sd0, 16'sd100, 16'sd0, 16'sd50, 16'sd2, 16'sd50, -16'sd2});
        send_word({16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd1, -16'sd1, 16'sd1, 16'sd7});
        // Extremes of the coordinate range.
        w = {16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
             16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000};
        send_word(w);
        w = {16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
             16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff};
        send_word(w);
        send_word('1);
        send_word('0);
        w = {16'sh8000, 16'sh0, 16'sh7fff, 16'sh0, 16'sh0, 16'sh8000, 16'sh1, 16'sh7fff};
        send_word(w);
    endtask

    initial
    begin
        int n;
        logic [15:0] eps_set[6];
        sb = new();
        sb.reset_eps();
        cycles   = 0;
        sent     = 0;
        rst_n    = 1'b0;
        start    = 1'b0;
        seg_in   = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        eps_set = '{16'd1, 16'd0, 16'd16, 16'hffff, 16'd3, 16'd200};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset tolerance, then again at zero and maximum.
        directed_words();
        drain();
        write_eps(16'd0);
        directed_words();
        drain();
        write_eps(16'hffff);
        directed_words();
        drain();

        // Random phases across tolerance settings.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_eps(ph == 5 ? 16'($urandom) : eps_set[ph]);
            n = 300;
            for (int i = 0; i < n; i++)
                send_word(rand_pair());
            drain();
        end

        $display("sent %0d words, checked %0d results", sent, sb.checked);
        $display("outcomes: %0d intersect, %0d apart, %0d coincident",
                 sb.hits[0], sb.hits[1], sb.hits[2]);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
